// ----- src/hbd_pkg.sv -----
// Shared constants, codes and helpers for the HTTP body dechunker.
`timescale 1ns / 1ps

package hbd_pkg;

    // Default line limits
    localparam int SIZE_LINE_MAX_DEF    = 32;
    localparam int TRAILER_LINE_MAX_DEF = 256;

    // Reset value of max_bytes
    localparam logic [31:0] MAX_BYTES_RST = 32'd4194304;

    // Input command codes
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_CLOSE = 2'd2;

    // Body framing modes
    localparam logic [1:0] MODE_UNTIL   = 2'd0;
    localparam logic [1:0] MODE_COUNTED = 2'd1;
    localparam logic [1:0] MODE_CHUNKED = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_BODY_MODE      = 2'd0;
    localparam logic [1:0] CFG_CONTENT_LENGTH = 2'd1;
    localparam logic [1:0] CFG_MAX_BYTES      = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_CLOSED     = 3'd1;
    localparam logic [2:0] ERR_SIZE_PARSE = 3'd2;
    localparam logic [2:0] ERR_SIZE_LONG  = 3'd3;
    localparam logic [2:0] ERR_CRLF       = 3'd4;
    localparam logic [2:0] ERR_TRAIL_LONG = 3'd5;
    localparam logic [2:0] ERR_TOO_LARGE  = 3'd6;

    // Characters of interest
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    // Result flags carried beside the payload byte
    typedef struct packed {
        logic [2:0] error_code;
        logic       body_done;
        logic       data_valid;
    } t_result_flags;

    // Hex digit decode: bit 4 set when the character is a hex digit
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// ----- src/http_body_dechunker_top.sv -----
// HTTP/1.1 response body de-framer: until close, content length and chunked.
// The result of an input transfer is registered and shown on the master side in the next cycle.
// Throughput: one input item per cycle; the output register drains while the
// next item is taken, so a stalled consumer only holds the input back.
// Each item updates the framing state through one level of logic (the widest
// path is the 32-bit payload limit compare). Reset is synchronous, active low:
// it clears the framing state, the output valid and the registers to defaults.
`timescale 1ns / 1ps

module http_body_dechunker_top
    import hbd_pkg::*;
#(
    parameter int SIZE_LINE_MAX    = SIZE_LINE_MAX_DEF,
    parameter int TRAILER_LINE_MAX = TRAILER_LINE_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] data_byte
    output logic [4:0]  m_axis_tuser,   // [0] data_valid, [1] body_done, [4:2] error_code
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    // Line counter must hold a full size line and one char past the trailer limit
    localparam int LEN_MAX = (SIZE_LINE_MAX > TRAILER_LINE_MAX + 1) ?
                             SIZE_LINE_MAX : TRAILER_LINE_MAX + 1;
    localparam int LEN_W   = $clog2(LEN_MAX + 1);
    localparam logic [LEN_W-1:0] SIZE_LIM  = LEN_W'(SIZE_LINE_MAX);
    localparam logic [LEN_W-1:0] TRAIL_LIM = LEN_W'(TRAILER_LINE_MAX);
    localparam logic [LEN_W-1:0] LEN_ONE   = LEN_W'(1);

    // Phase codes
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_UNTIL   = 3'd1;
    localparam logic [2:0] PH_COUNTED = 3'd2;
    localparam logic [2:0] PH_SIZE    = 3'd3;
    localparam logic [2:0] PH_DATA    = 3'd4;
    localparam logic [2:0] PH_CRLF    = 3'd5;
    localparam logic [2:0] PH_TRAILER = 3'd6;

    // Configuration registers
    logic [1:0]  r_body_mode;
    logic [31:0] r_content_length;
    logic [31:0] r_max_bytes;

    // Framing state
    logic [2:0]       r_phase,          n_phase;
    logic [LEN_W-1:0] r_line_len,       n_line_len;
    logic [31:0]      r_size_acc,       n_size_acc;
    logic             r_digit_seen,     n_digit_seen;
    logic             r_past_semicolon, n_past_semicolon;
    logic             r_line_bad,       n_line_bad;
    logic             r_pending_cr,     n_pending_cr;
    logic [31:0]      r_chunk_left,     n_chunk_left;
    logic [31:0]      r_content_left,   n_content_left;
    logic             r_crlf_seen,      n_crlf_seen;
    logic             r_crlf_ok,        n_crlf_ok;
    logic [31:0]      r_payload_count,  n_payload_count;

    // Output register
    logic          r_out_valid;
    logic [7:0]    r_out_byte,  n_out_byte;
    t_result_flags r_out_flags, n_out_flags;

    logic       in_xfer;
    logic [7:0] c;
    logic [1:0] cmd;
    logic       too_large;
    logic [4:0] hex;
    logic       is_cr;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign c             = s_axis_tdata;
    assign cmd           = s_axis_tuser;
    assign too_large     = (r_payload_count >= r_max_bytes);
    assign hex           = hex_decode(c);
    assign is_cr         = (c == CH_CR);

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tuser  = r_out_flags;

    // Next framing state and result for the item at the input
    always_comb begin
        logic p_semi, p_bad;
        n_phase          = r_phase;
        n_line_len       = r_line_len;
        n_size_acc       = r_size_acc;
        n_digit_seen     = r_digit_seen;
        n_past_semicolon = r_past_semicolon;
        n_line_bad       = r_line_bad;
        n_pending_cr     = r_pending_cr;
        n_chunk_left     = r_chunk_left;
        n_content_left   = r_content_left;
        n_crlf_seen      = r_crlf_seen;
        n_crlf_ok        = r_crlf_ok;
        n_payload_count  = r_payload_count;
        n_out_byte       = 8'd0;
        n_out_flags      = '0;
        p_semi           = r_past_semicolon;
        p_bad            = r_line_bad;

        case (cmd)
            CMD_START: begin
                n_line_len       = '0;
                n_size_acc       = '0;
                n_digit_seen     = 1'b0;
                n_past_semicolon = 1'b0;
                n_line_bad       = 1'b0;
                n_pending_cr     = 1'b0;
                n_chunk_left     = '0;
                n_crlf_seen      = 1'b0;
                n_crlf_ok        = 1'b1;
                n_payload_count  = '0;
                n_content_left   = '0;
                if (r_body_mode == MODE_COUNTED) begin
                    n_content_left = r_content_length;
                    if (r_content_length == 32'd0) begin
                        n_out_flags.body_done = 1'b1;
                        n_phase               = PH_IDLE;
                    end else begin
                        n_phase = PH_COUNTED;
                    end
                end else if (r_body_mode == MODE_CHUNKED) begin
                    n_phase = PH_SIZE;
                end else begin
                    n_phase = PH_UNTIL;
                end
            end
            CMD_CLOSE: begin
                if (r_phase == PH_UNTIL || r_phase == PH_TRAILER) begin
                    n_out_flags.body_done = 1'b1;
                    n_phase               = PH_IDLE;
                end else if (r_phase != PH_IDLE) begin
                    n_out_flags.error_code = ERR_CLOSED;
                    n_phase                = PH_IDLE;
                end
            end
            CMD_BYTE: begin
                unique case (r_phase) inside
                    PH_UNTIL, PH_COUNTED, PH_DATA: begin
                        // payload byte, subject to the size limit
                        if (too_large) begin
                            n_out_flags.error_code = ERR_TOO_LARGE;
                            n_phase                = PH_IDLE;
                        end else begin
                            n_payload_count        = r_payload_count + 32'd1;
                            n_out_flags.data_valid = 1'b1;
                            n_out_byte             = c;
                            if (r_phase == PH_COUNTED) begin
                                n_content_left = r_content_left - 32'd1;
                                if (r_content_left == 32'd1) begin
                                    n_out_flags.body_done = 1'b1;
                                    n_phase               = PH_IDLE;
                                end
                            end else if (r_phase == PH_DATA) begin
                                n_chunk_left = r_chunk_left - 32'd1;
                                if (r_chunk_left == 32'd1) begin
                                    n_crlf_seen = 1'b0;
                                    n_crlf_ok   = 1'b1;
                                    n_phase     = PH_CRLF;
                                end
                            end
                        end
                    end
                    PH_SIZE: begin
                        if (c == CH_LF) begin
                            n_line_len       = '0;
                            n_size_acc       = '0;
                            n_digit_seen     = 1'b0;
                            n_past_semicolon = 1'b0;
                            n_line_bad       = 1'b0;
                            n_pending_cr     = 1'b0;
                            if (!r_digit_seen || r_line_bad) begin
                                n_out_flags.error_code = ERR_SIZE_PARSE;
                                n_phase                = PH_IDLE;
                            end else if (r_size_acc == 32'd0) begin
                                n_phase = PH_TRAILER;
                            end else begin
                                n_chunk_left = r_size_acc;
                                n_phase      = PH_DATA;
                            end
                        end else begin
                            // a held CR that was not followed by LF is a bad char
                            if (r_pending_cr && !p_semi && !p_bad) begin
                                p_bad = 1'b1;
                            end
                            n_pending_cr = is_cr;
                            if (!is_cr && !p_semi && !p_bad) begin
                                if (c == CH_SEMI) begin
                                    p_semi = 1'b1;
                                end else if (hex[4]) begin
                                    n_size_acc   = {r_size_acc[27:0], hex[3:0]};
                                    n_digit_seen = 1'b1;
                                end else begin
                                    p_bad = 1'b1;
                                end
                            end
                            n_past_semicolon = p_semi;
                            n_line_bad       = p_bad;
                            n_line_len       = r_line_len + LEN_ONE;
                            if (r_line_len + LEN_ONE >= SIZE_LIM) begin
                                n_out_flags.error_code = ERR_SIZE_LONG;
                                n_phase                = PH_IDLE;
                            end
                        end
                    end
                    PH_CRLF: begin
                        if (!r_crlf_seen) begin
                            n_crlf_ok   = is_cr;
                            n_crlf_seen = 1'b1;
                        end else begin
                            n_crlf_seen = 1'b0;
                            n_crlf_ok   = 1'b1;
                            if (!(r_crlf_ok && c == CH_LF)) begin
                                n_out_flags.error_code = ERR_CRLF;
                                n_phase                = PH_IDLE;
                            end else begin
                                n_line_len       = '0;
                                n_size_acc       = '0;
                                n_digit_seen     = 1'b0;
                                n_past_semicolon = 1'b0;
                                n_line_bad       = 1'b0;
                                n_pending_cr     = 1'b0;
                                n_phase          = PH_SIZE;
                            end
                        end
                    end
                    PH_TRAILER: begin
                        if (c == CH_LF) begin
                            // empty line or a lone CR ends the body
                            if (r_line_len == '0 || (r_line_len == LEN_ONE && r_pending_cr))
                            begin
                                n_out_flags.body_done = 1'b1;
                                n_phase               = PH_IDLE;
                            end
                            n_line_len       = '0;
                            n_size_acc       = '0;
                            n_digit_seen     = 1'b0;
                            n_past_semicolon = 1'b0;
                            n_line_bad       = 1'b0;
                            n_pending_cr     = 1'b0;
                        end else begin
                            n_pending_cr = is_cr;
                            n_line_len   = r_line_len + LEN_ONE;
                            if (r_line_len >= TRAIL_LIM) begin
                                n_out_flags.error_code = ERR_TRAIL_LONG;
                                n_phase                = PH_IDLE;
                            end
                        end
                    end
                    default: begin
                        // idle: bytes are dropped
                    end
                endcase
            end
            default: begin
                // unknown command: no state change
            end
        endcase
    end

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_body_mode      <= MODE_UNTIL;
            r_content_length <= '0;
            r_max_bytes      <= MAX_BYTES_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BODY_MODE:      r_body_mode      <= i_cfg_data[1:0];
                CFG_CONTENT_LENGTH: r_content_length <= i_cfg_data;
                CFG_MAX_BYTES:      r_max_bytes      <= i_cfg_data;
                default: begin
                    // writes past the register list are dropped
                end
            endcase
        end
    end

    // Framing state update on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_IDLE;
            r_line_len       <= '0;
            r_size_acc       <= '0;
            r_digit_seen     <= 1'b0;
            r_past_semicolon <= 1'b0;
            r_line_bad       <= 1'b0;
            r_pending_cr     <= 1'b0;
            r_chunk_left     <= '0;
            r_content_left   <= '0;
            r_crlf_seen      <= 1'b0;
            r_crlf_ok        <= 1'b1;
            r_payload_count  <= '0;
        end else if (in_xfer) begin
            r_phase          <= n_phase;
            r_line_len       <= n_line_len;
            r_size_acc       <= n_size_acc;
            r_digit_seen     <= n_digit_seen;
            r_past_semicolon <= n_past_semicolon;
            r_line_bad       <= n_line_bad;
            r_pending_cr     <= n_pending_cr;
            r_chunk_left     <= n_chunk_left;
            r_content_left   <= n_content_left;
            r_crlf_seen      <= n_crlf_seen;
            r_crlf_ok        <= n_crlf_ok;
            r_payload_count  <= n_payload_count;
        end
    end

    // Output register: valid control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register: payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_byte  <= n_out_byte;
            r_out_flags <= n_out_flags;
        end
    end

endmodule

// ----- dv/http_body_dechunker_top_test.sv -----
// Self-checking testbench for the HTTP body dechunker: directed table, then random bodies.
`timescale 1ns / 1ps

module http_body_dechunker_top_test;
    import hbd_pkg::*;

    // Codes the block must ignore or treat as a fallback
    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DIR_ROWS    = 35;

    // One decoded result, as the block presents it
    typedef struct packed {
        logic       data_valid;
        logic [7:0] data_byte;
        logic       body_done;
        logic [2:0] error_code;
    } t_dec_result;

    // Directed row: either a register write or one input transfer
    typedef struct packed {
        logic        is_cfg;
        logic [1:0]  sel;       // command, or register index for a write
        logic [31:0] value;     // byte in [7:0], or write data
        logic        has_res;   // result typed in below instead of predicted
        t_dec_result res;
    } t_dir_row;

    typedef enum logic [2:0] {
        ST_IDLE, ST_UNTIL, ST_COUNTED, ST_SIZE, ST_DATA, ST_CRLF, ST_TRAILER
    } t_body_phase;

    localparam t_dec_result R_ZERO = '0;

    // DUT connections
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic [1:0]  s_axis_tuser = 2'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic [4:0]  m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = 2'd0;
    logic [31:0] i_cfg_data = 32'd0;

    // Register mirror
    logic [1:0]  cfg_mode = MODE_UNTIL;
    logic [31:0] cfg_clen = 32'd0;
    logic [31:0] cfg_maxb = MAX_BYTES_RST;

    // Framing state mirror
    t_body_phase body_ph = ST_IDLE;
    logic [8:0]  line_len = 9'd0;
    logic [31:0] size_acc = 32'd0;
    logic        digit_seen = 1'b0;
    logic        past_semi = 1'b0;
    logic        line_bad = 1'b0;
    logic        pending_cr = 1'b0;
    logic [31:0] chunk_left = 32'd0;
    logic [31:0] content_left = 32'd0;
    logic [1:0]  crlf_seen = 2'd0;
    logic        crlf_ok = 1'b1;
    logic [31:0] payload_cnt = 32'd0;

    t_dec_result decoded_q[$];
    logic [9:0]  stim_q[$];     // {cmd, byte}
    int          mismatches = 0;
    int          cycle_cnt = 0;
    int          src_gap_pct = 22;
    int          sink_stall_pct = 63;

    t_dir_row dir_tbl [DIR_ROWS] = '{
        '{1'b0, CMD_BYTE,    32'h41, 1'b1, R_ZERO},     // byte while idle
        '{1'b0, CMD_CLOSE,   32'h00, 1'b1, R_ZERO},     // close while idle
        '{1'b0, CMD_UNUSED,  32'hFF, 1'b1, R_ZERO},
        '{1'b0, CMD_START,   32'h00, 1'b1, R_ZERO},
        '{1'b0, CMD_BYTE,    32'hFF, 1'b1, '{1'b1, 8'hFF, 1'b0, ERR_NONE}},
        '{1'b0, CMD_BYTE,    32'h00, 1'b1, '{1'b1, 8'h00, 1'b0, ERR_NONE}},
        '{1'b0, CMD_CLOSE,   32'h00, 1'b1, '{1'b0, 8'h00, 1'b1, ERR_NONE}},
        '{1'b1, CFG_BODY_MODE,      {30'd0, MODE_COUNTED}, 1'b0, R_ZERO},
        '{1'b1, CFG_CONTENT_LENGTH, 32'd0,                 1'b0, R_ZERO},
        '{1'b0, CMD_START,   32'h00, 1'b1, '{1'b0, 8'h00, 1'b1, ERR_NONE}},  // zero length
        '{1'b1, CFG_CONTENT_LENGTH, 32'hFFFF_FFFF,         1'b0, R_ZERO},
        '{1'b0, CMD_START,   32'h00, 1'b1, R_ZERO},
        '{1'b0, CMD_BYTE,    32'h5A, 1'b1, '{1'b1, 8'h5A, 1'b0, ERR_NONE}},
        '{1'b0, CMD_CLOSE,   32'h00, 1'b1, '{1'b0, 8'h00, 1'b0, ERR_CLOSED}},
        '{1'b1, CFG_BODY_MODE,      {30'd0, MODE_CHUNKED}, 1'b0, R_ZERO},
        '{1'b1, CFG_MAX_BYTES,      32'd1,                 1'b0, R_ZERO},
        '{1'b0, CMD_START,   32'h00, 1'b0, R_ZERO},
        '{1'b0, CMD_BYTE,    32'h32, 1'b0, R_ZERO},     // "2"
        '{1'b0, CMD_BYTE,    32'h0D, 1'b0, R_ZERO},
        '{1'b0, CMD_BYTE,    32'h0A, 1'b0, R_ZERO},
        '{1'b0, CMD_BYTE,    32'h61, 1'b1, '{1'b1, 8'h61, 1'b0, ERR_NONE}},
        '{1'b0, CMD_BYTE,    32'h62, 1'b1, '{1'b0, 8'h00, 1'b0, ERR_TOO_LARGE}},
        '{1'b1, CFG_MAX_BYTES,      32'd0,                 1'b0, R_ZERO},
        '{1'b1, CFG_BODY_MODE,      {30'd0, MODE_UNUSED},  1'b0, R_ZERO},
        '{1'b0, CMD_START,   32'h00, 1'b0, R_ZERO},
        '{1'b0, CMD_BYTE,    32'h80, 1'b1, '{1'b0, 8'h00, 1'b0, ERR_TOO_LARGE}},
        '{1'b1, CFG_MAX_BYTES,      32'hFFFF_FFFF,         1'b0, R_ZERO},
        '{1'b0, CMD_START,   32'h00, 1'b0, R_ZERO},
        '{1'b0, CMD_BYTE,    32'h80, 1'b1, '{1'b1, 8'h80, 1'b0, ERR_NONE}},
        '{1'b0, CMD_START,   32'h00, 1'b1, R_ZERO},     // restart while busy
        '{1'b0, CMD_CLOSE,   32'h00, 1'b1, '{1'b0, 8'h00, 1'b1, ERR_NONE}},
        '{1'b1, CFG_BODY_MODE,      {30'd0, MODE_CHUNKED}, 1'b0, R_ZERO},
        '{1'b0, CMD_START,   32'h00, 1'b0, R_ZERO},
        '{1'b0, CMD_BYTE,    32'h67, 1'b0, R_ZERO},     // "g" is not hex
        '{1'b0, CMD_BYTE,    32'h0A, 1'b1, '{1'b0, 8'h00, 1'b0, ERR_SIZE_PARSE}}
    };

    http_body_dechunker_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ---------------- predictor ----------------

    function automatic void clear_line();
        line_len   = 9'd0;
        size_acc   = 32'd0;
        digit_seen = 1'b0;
        past_semi  = 1'b0;
        line_bad   = 1'b0;
        pending_cr = 1'b0;
    endfunction

    // Fold one size-line character into the hex accumulator
    function automatic void size_char(input logic [7:0] c);
        logic [3:0] nib;
        if (past_semi || line_bad) return;
        if (c == CH_SEMI) begin
            past_semi = 1'b1;
            return;
        end
        if (c >= 8'h30 && c <= 8'h39) begin         // 0-9
            nib = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin  // a-f
            nib = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin  // A-F
            nib = 4'(c - 8'h37);
        end else begin
            line_bad = 1'b1;
            return;
        end
        size_acc   = {size_acc[27:0], 4'd0} + {28'd0, nib};
        digit_seen = 1'b1;
    endfunction

    // Pass a payload byte unless the byte limit is hit
    function automatic logic pass_byte(input logic [7:0] c, inout t_dec_result r);
        if ({1'b0, payload_cnt} + 33'd1 > {1'b0, cfg_maxb}) begin
            r.error_code = ERR_TOO_LARGE;
            body_ph = ST_IDLE;
            return 1'b0;
        end
        payload_cnt = payload_cnt + 32'd1;
        r.data_valid = 1'b1;
        r.data_byte  = c;
        return 1'b1;
    endfunction

    function automatic t_dec_result dechunk_step(input logic [1:0] cmd, input logic [7:0] c);
        t_dec_result r;
        logic        ok;
        logic [31:0] sz;
        r = '0;
        case (cmd)
            CMD_START: begin
                clear_line();
                chunk_left   = 32'd0;
                crlf_seen    = 2'd0;
                crlf_ok      = 1'b1;
                payload_cnt  = 32'd0;
                content_left = 32'd0;
                if (cfg_mode == MODE_COUNTED) begin
                    content_left = cfg_clen;
                    if (content_left == 32'd0) begin
                        r.body_done = 1'b1;
                        body_ph = ST_IDLE;
                    end else begin
                        body_ph = ST_COUNTED;
                    end
                end else if (cfg_mode == MODE_CHUNKED) begin
                    body_ph = ST_SIZE;
                end else begin
                    body_ph = ST_UNTIL;
                end
            end
            CMD_CLOSE: begin
                if (body_ph == ST_UNTIL || body_ph == ST_TRAILER) begin
                    r.body_done = 1'b1;
                    body_ph = ST_IDLE;
                end else if (body_ph != ST_IDLE) begin
                    r.error_code = ERR_CLOSED;
                    body_ph = ST_IDLE;
                end
            end
            CMD_BYTE: begin
                case (body_ph)
                    ST_UNTIL: begin
                        void'(pass_byte(c, r));
                    end
                    ST_COUNTED: begin
                        if (pass_byte(c, r)) begin
                            content_left = content_left - 32'd1;
                            if (content_left == 32'd0) begin
                                r.body_done = 1'b1;
                                body_ph = ST_IDLE;
                            end
                        end
                    end
                    ST_SIZE: begin
                        if (c == CH_LF) begin
                            ok = digit_seen && !line_bad;
                            sz = size_acc;
                            clear_line();
                            if (!ok) begin
                                r.error_code = ERR_SIZE_PARSE;
                                body_ph = ST_IDLE;
                            end else if (sz == 32'd0) begin
                                body_ph = ST_TRAILER;
                            end else begin
                                chunk_left = sz;
                                body_ph = ST_DATA;
                            end
                        end else begin
                            // a held CR that is not followed by LF is an ordinary character
                            if (pending_cr) begin
                                size_char(CH_CR);
                                pending_cr = 1'b0;
                            end
                            if (c == CH_CR) pending_cr = 1'b1;
                            else size_char(c);
                            line_len = line_len + 9'd1;
                            if (line_len >= 9'(SIZE_LINE_MAX_DEF)) begin
                                r.error_code = ERR_SIZE_LONG;
                                body_ph = ST_IDLE;
                            end
                        end
                    end
                    ST_DATA: begin
                        if (pass_byte(c, r)) begin
                            chunk_left = chunk_left - 32'd1;
                            if (chunk_left == 32'd0) begin
                                crlf_seen = 2'd0;
                                crlf_ok   = 1'b1;
                                body_ph   = ST_CRLF;
                            end
                        end
                    end
                    ST_CRLF: begin
                        if (crlf_seen == 2'd0) begin
                            crlf_ok   = (c == CH_CR);
                            crlf_seen = 2'd1;
                        end else begin
                            ok = crlf_ok && (c == CH_LF);
                            crlf_seen = 2'd0;
                            crlf_ok   = 1'b1;
                            if (!ok) begin
                                r.error_code = ERR_CRLF;
                                body_ph = ST_IDLE;
                            end else begin
                                clear_line();
                                body_ph = ST_SIZE;
                            end
                        end
                    end
                    ST_TRAILER: begin
                        if (c == CH_LF) begin
                            // empty line or lone CR ends the trailer section
                            if (line_len == 9'd0 || (line_len == 9'd1 && pending_cr)) begin
                                r.body_done = 1'b1;
                                body_ph = ST_IDLE;
                            end
                            clear_line();
                        end else begin
                            pending_cr = (c == CH_CR);
                            line_len = line_len + 9'd1;
                            if (line_len > 9'(TRAILER_LINE_MAX_DEF)) begin
                                r.error_code = ERR_TRAIL_LONG;
                                body_ph = ST_IDLE;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        return r;
    endfunction

    // ---------------- drivers ----------------

    // One input transfer; returns on the falling edge after acceptance
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] b,
                             input logic has_res, input t_dec_result res);
        t_dec_result r;
        while ($urandom_range(99) < src_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        r = dechunk_step(cmd, b);
        decoded_q.insert(decoded_q.size(), has_res ? res : r);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_BODY_MODE:      cfg_mode = val[1:0];
            CFG_CONTENT_LENGTH: cfg_clen = val;
            CFG_MAX_BYTES:      cfg_maxb = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Hold the sender off until every pending result has drained
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (decoded_q.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic push_item(input logic [1:0] cmd, input logic [7:0] b);
        stim_q.insert(stim_q.size(), {cmd, b});
    endtask

    // Hex size line: optional padding, wrap past 32 bits, extension, CR
    task automatic push_size_line(input logic [31:0] sz);
        int         pick;
        int         ndig;
        logic       upper;
        logic [3:0] nib;
        pick  = $urandom_range(99);
        upper = 1'($urandom_range(1));
        ndig  = 1;
        while (ndig < 8 && (sz >> (4 * ndig)) != 32'd0) ndig++;
        if (pick < 5) begin
            // padding that lands the line around the length limit
            repeat ($urandom_range(32, 27)) push_item(CMD_BYTE, 8'h30);
        end else if (pick < 10) begin
            // leading 1 is shifted out of the 32-bit size
            push_item(CMD_BYTE, 8'h31);
            ndig = 8;
        end else begin
            repeat ($urandom_range(2)) push_item(CMD_BYTE, 8'h30);
        end
        for (int i = ndig - 1; i >= 0; i--) begin
            nib = sz[4 * i +: 4];
            push_item(CMD_BYTE, (nib < 4'd10) ? 8'h30 + nib : (upper ? 8'h37 : 8'h57) + nib);
        end
        if ($urandom_range(4) == 0) begin
            push_item(CMD_BYTE, CH_SEMI);
            repeat ($urandom_range(4)) push_item(CMD_BYTE, 8'($urandom_range(8'h7E, 8'h21)));
        end
        if ($urandom_range(4) != 0) push_item(CMD_BYTE, CH_CR);
        push_item(CMD_BYTE, CH_LF);
    endtask

    task automatic pick_config();
        int          pick;
        logic [1:0]  mode;
        logic [31:0] clen;
        logic [31:0] maxb;
        pick = $urandom_range(99);
        mode = (pick < 15) ? MODE_UNTIL : (pick < 40) ? MODE_COUNTED :
               (pick < 92) ? MODE_CHUNKED : MODE_UNUSED;
        pick = $urandom_range(99);
        clen = (pick < 8) ? 32'd0 : (pick < 14) ? 32'hFFFF_FFFF : 32'($urandom_range(12, 1));
        pick = $urandom_range(99);
        maxb = (pick < 60) ? 32'hFFFF_FFFF : (pick < 68) ? MAX_BYTES_RST :
               (pick < 76) ? 32'd0 : (pick < 88) ? clen - 32'd1 : 32'($urandom_range(16, 1));
        write_reg(CFG_BODY_MODE, {30'd0, mode});
        write_reg(CFG_CONTENT_LENGTH, clen);
        write_reg(CFG_MAX_BYTES, maxb);
    endtask

    // Mostly well-formed body for the current mode, sometimes damaged
    task automatic build_body();
        int          n;
        int          pick;
        int          pos;
        logic [31:0] sz;
        stim_q.delete();
        push_item(CMD_START, 8'($urandom));
        if (cfg_mode == MODE_COUNTED) begin
            if (cfg_clen > 32'd40) begin
                repeat ($urandom_range(8)) push_item(CMD_BYTE, 8'($urandom));
                push_item(CMD_CLOSE, 8'($urandom));
            end else if ($urandom_range(4) == 0) begin
                repeat ($urandom_range(int'(cfg_clen))) push_item(CMD_BYTE, 8'($urandom));
                push_item(CMD_CLOSE, 8'($urandom));
            end else begin
                repeat (int'(cfg_clen)) push_item(CMD_BYTE, 8'($urandom));
            end
        end else if (cfg_mode == MODE_CHUNKED) begin
            repeat ($urandom_range(3)) begin
                sz = ($urandom_range(15) == 0) ? 32'($urandom_range(40, 17))
                                               : 32'($urandom_range(6, 1));
                push_size_line(sz);
                repeat (int'(sz)) push_item(CMD_BYTE, 8'($urandom));
                push_item(CMD_BYTE, CH_CR);
                push_item(CMD_BYTE, CH_LF);
            end
            push_size_line(32'd0);
            repeat ($urandom_range(2)) begin
                n = ($urandom_range(24) == 0) ? $urandom_range(258, 254) : $urandom_range(8, 1);
                repeat (n) push_item(CMD_BYTE, 8'($urandom_range(8'h7E, 8'h21)));
                push_item(CMD_BYTE, CH_CR);
                push_item(CMD_BYTE, CH_LF);
            end
            pick = $urandom_range(99);
            if (pick < 60) begin
                push_item(CMD_BYTE, CH_CR);
                push_item(CMD_BYTE, CH_LF);
            end else if (pick < 80) begin
                push_item(CMD_BYTE, CH_LF);
            end else begin
                push_item(CMD_CLOSE, 8'($urandom));
            end
        end else begin
            repeat ($urandom_range(10)) push_item(CMD_BYTE, 8'($urandom));
            if ($urandom_range(9) != 0) push_item(CMD_CLOSE, 8'($urandom));
        end

        // damage: corrupt a byte, stray command, cut short, restart midway
        if (stim_q.size() > 1) begin
            pick = $urandom_range(99);
            pos  = $urandom_range(stim_q.size() - 1, 1);
            if (pick < 12) begin
                stim_q[pos] = {CMD_BYTE, 8'($urandom)};
            end else if (pick < 17) begin
                stim_q.insert(pos, {CMD_UNUSED, 8'($urandom)});
            end else if (pick < 22) begin
                while (stim_q.size() > pos) stim_q.delete(stim_q.size() - 1);
                push_item(CMD_CLOSE, 8'($urandom));
            end else if (pick < 25) begin
                stim_q.insert(pos, {CMD_START, 8'($urandom)});
            end
        end
    endtask

    task automatic run_random(input int quota);
        int         sent;
        logic [9:0] item;
        sent = 0;
        while (sent < quota) begin
            if ($urandom_range(2) == 0) begin
                wait_quiet();
                pick_config();
            end
            build_body();
            while (stim_q.size() != 0) begin
                item = stim_q.pop_front();
                sent++;
                send_item(item[9:8], item[7:0], 1'b0, R_ZERO);
            end
        end
    endtask

    // ---------------- receiver and checks ----------------

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin : check_results
        t_dec_result want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (decoded_q.size() == 0) begin
                $error("result transfer with nothing pending: tuser %0h tdata %0h",
                       m_axis_tuser, m_axis_tdata);
                mismatches++;
            end else begin
                want = decoded_q.pop_front();
                if (m_axis_tuser[0] !== want.data_valid) begin
                    $error("data_valid: expected %0d, got %0d", want.data_valid, m_axis_tuser[0]);
                    mismatches++;
                end
                if (m_axis_tdata !== want.data_byte) begin
                    $error("data_byte: expected %0h, got %0h", want.data_byte, m_axis_tdata);
                    mismatches++;
                end
                if (m_axis_tuser[1] !== want.body_done) begin
                    $error("body_done: expected %0d, got %0d", want.body_done, m_axis_tuser[1]);
                    mismatches++;
                end
                if (m_axis_tuser[4:2] !== want.error_code) begin
                    $error("error_code: expected %0d, got %0d", want.error_code,
                           m_axis_tuser[4:2]);
                    mismatches++;
                end
            end
        end
    end

    // Run time guard
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("[http_body_dechunker_top] ERROR");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_tbl[i].is_cfg) begin
                wait_quiet();
                write_reg(dir_tbl[i].sel, dir_tbl[i].value);
            end else begin
                send_item(dir_tbl[i].sel, dir_tbl[i].value[7:0], dir_tbl[i].has_res,
                          dir_tbl[i].res);
            end
        end

        // random bodies under three flow-control profiles
        run_random(130);
        src_gap_pct    = 63;
        sink_stall_pct = 22;
        run_random(130);
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        run_random(130);

        wait_quiet();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[http_body_dechunker_top] OK");
        end else begin
            $display("[http_body_dechunker_top] ERROR");
        end
        $finish;
    end

endmodule
